// ===== hw/rtl/pia_kpm_pkg.sv =====
// shared types and constants for the keypad matrix port
package pia_kpm_pkg;

	// operation codes
	localparam logic [2:0] OP_READ         = 3'd0;
	localparam logic [2:0] OP_WRITE        = 3'd1;
	localparam logic [2:0] OP_KEY_DOWN     = 3'd2;
	localparam logic [2:0] OP_KEY_UP       = 3'd3;
	localparam logic [2:0] OP_STEP_PRESS   = 3'd4;
	localparam logic [2:0] OP_STEP_RELEASE = 3'd5;
	localparam logic [2:0] OP_CLEAR_KEYS   = 3'd6;

	// register select codes
	localparam logic [1:0] REG_DATA    = 2'd0;
	localparam logic [1:0] REG_CONTROL = 2'd1;

	// control register bit that picks the direction register
	localparam int unsigned CTRL_DIR_BIT = 2;

	localparam logic [7:0] PORT_IDLE = 8'hFF;

	typedef struct packed {
		logic [2:0] operation;
		logic [1:0] register_select;
		logic [7:0] write_data;
		logic [3:0] key_index;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       direction_chosen;
		logic       step_flag;
	} result_t;

endpackage

// ===== hw/rtl/pia_kpm_input.sv =====
// input register stage with stall back to the producer
module pia_kpm_input (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pia_kpm_pkg::item_t  item,
	input  logic                advance,
	output logic                valid_s1,
	output pia_kpm_pkg::item_t  item_s1
);
	import pia_kpm_pkg::*;

	// hold the producer only while a held item cannot move on
	assign item_stall = valid_s1 && !advance;

	// valid bit of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// payload capture on a transfer
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end
endmodule

// ===== hw/rtl/pia_kpm_core.sv =====
// port registers, key matrix state and the per-item update and scan logic
module pia_kpm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  pia_kpm_pkg::item_t    item_s1,
	input  logic                  step_flag_invert,
	output pia_kpm_pkg::result_t  result_next
);
	import pia_kpm_pkg::*;

	logic [15:0] key_pressed_q;
	logic        direction_selected_q;
	logic [7:0]  output_mask_q;
	logic [7:0]  output_value_q;
	logic        step_button_q;

	logic [15:0] key_pressed_d;
	logic        direction_selected_d;
	logic [7:0]  output_mask_d;
	logic [7:0]  output_value_d;
	logic        step_button_d;

	logic [15:0] key_bit;
	logic [7:0]  scan;
	logic [7:0]  port_value;
	logic [7:0]  read_data;
	logic        dir_chosen;

	assign key_bit = 16'(1) << item_s1.key_index;

	// matrix scan: driven-low rows pull columns, driven-low columns pull rows
	always_comb begin
		scan = PORT_IDLE;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (key_pressed_q[4 * r + c] && !output_value_q[r]) begin
					scan[4 + c] = 1'b0;
				end
				if (key_pressed_q[4 * r + c] && !output_value_q[4 + c]) begin
					scan[r] = 1'b0;
				end
			end
		end
	end

	// inputs read back the matrix, outputs read back the driven value
	assign port_value = (scan & ~output_mask_q) | (output_value_q & output_mask_q);

	// operation decode and next state
	always_comb begin
		key_pressed_d        = key_pressed_q;
		direction_selected_d = direction_selected_q;
		output_mask_d        = output_mask_q;
		output_value_d       = output_value_q;
		step_button_d        = step_button_q;
		read_data            = PORT_IDLE;
		dir_chosen           = 1'b0;
		unique case (item_s1.operation)
			OP_READ: begin
				if (item_s1.register_select == REG_DATA && !direction_selected_q) begin
					read_data = port_value;
				end
			end
			OP_WRITE: begin
				if (item_s1.register_select == REG_CONTROL) begin
					direction_selected_d = item_s1.write_data[CTRL_DIR_BIT];
					dir_chosen           = item_s1.write_data[CTRL_DIR_BIT];
				end else if (item_s1.register_select == REG_DATA) begin
					if (direction_selected_q) begin
						output_mask_d = item_s1.write_data;
					end else begin
						output_value_d = (item_s1.write_data & output_mask_q)
							| ~output_mask_q;
					end
				end
			end
			OP_KEY_DOWN:     key_pressed_d = key_pressed_q | key_bit;
			OP_KEY_UP:       key_pressed_d = key_pressed_q & ~key_bit;
			OP_STEP_PRESS:   step_button_d = 1'b0;
			OP_STEP_RELEASE: step_button_d = 1'b1;
			OP_CLEAR_KEYS:   key_pressed_d = '0;
			default: begin
			end
		endcase
	end

	assign result_next.read_data        = read_data;
	assign result_next.direction_chosen = dir_chosen;
	assign result_next.step_flag        = step_button_d ^ step_flag_invert;

	// state registers, updated as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pressed_q        <= '0;
			direction_selected_q <= 1'b1;
			output_mask_q        <= '0;
			output_value_q       <= PORT_IDLE;
			step_button_q        <= 1'b1;
		end else if (fire) begin
			key_pressed_q        <= key_pressed_d;
			direction_selected_q <= direction_selected_d;
			output_mask_q        <= output_mask_d;
			output_value_q       <= output_value_d;
			step_button_q        <= step_button_d;
		end
	end
endmodule

// ===== hw/rtl/pia_kpm_result.sv =====
// result register feeding the consumer
module pia_kpm_result (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  pia_kpm_pkg::result_t  result_next,
	output logic                  advance,
	output logic                  result_valid,
	input  logic                  result_stall,
	output pia_kpm_pkg::result_t  result
);
	import pia_kpm_pkg::*;

	// register may load when empty or when its content transfers now
	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result <= result_next;
		end
	end
endmodule

// ===== hw/rtl/pia_port_keypad_matrix.sv =====
// top level of the keypad matrix port
// Port A of a peripheral interface adapter scanning a 4x4 key matrix. Each
// transfer on the item channel is a register read or write, a key event, a
// step button event or a clear of all keys, and gives exactly one result.
// An item is captured in the input register at its transfer and its result
// is loaded into the result register when that register can advance, which a
// stall from the consumer can delay; with no stall from the consumer one item
// is taken every cycle, as the decode and matrix scan between the two
// registers are combinational.
// The configuration channel writes the step flag inversion bit and is
// always ready.
module pia_port_keypad_matrix (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  pia_kpm_pkg::item_t    item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output pia_kpm_pkg::result_t  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);
	import pia_kpm_pkg::*;

	logic    advance;
	logic    valid_s1;
	item_t   item_s1;
	result_t result_next;
	logic    step_flag_invert_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_flag_invert_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			step_flag_invert_q <= cfg_data;
		end
	end

	pia_kpm_input u_input (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	pia_kpm_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (valid_s1 && advance),
		.item_s1          (item_s1),
		.step_flag_invert (step_flag_invert_q),
		.result_next      (result_next)
	);

	pia_kpm_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.result_next  (result_next),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// the producer is held only behind a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && valid_s1))
		else $error("item stall without a blocked result");

	// a transferred result with nothing behind it leaves the register empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !valid_s1) |=> !result_valid)
		else $error("result repeated after transfer");

	// the direction flag only comes from a control write, which reads idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.direction_chosen) |-> (result.read_data == PORT_IDLE))
		else $error("direction flag on a read result");
endmodule

// ===== bench/pia_port_keypad_matrix_test.sv =====
// self-checking bench for the keypad matrix port against an in-bench predictor
`timescale 1ns / 1ps

module pia_port_keypad_matrix_test;
	import pia_kpm_pkg::*;

	// codes the package leaves unnamed
	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	localparam int IDLE_PERCENT = 37;
	localparam int ITEM_BITS = $bits(item_t);

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;

	// predicted port state
	logic [15:0] keys_down = '0;
	logic        ddr_selected = 1'b1;
	logic [7:0]  ddr_mask = 8'h00;
	logic [7:0]  port_out = 8'hFF;
	logic        step_released = 1'b1;
	logic        flag_invert = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      mismatch_count = 0;
	bit      steady = 1'b0;

	pia_port_keypad_matrix u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t: %s", $realtime, msg);
	endtask

	// apply one item to the predicted state and return the port's answer
	function automatic result_t port_predict(item_t it);
		result_t     r;
		logic [7:0]  scan;
		int          row;
		int          col;
		r.read_data = PORT_IDLE;
		r.direction_chosen = 1'b0;
		case (it.operation)
			OP_READ: begin
				if (it.register_select == REG_DATA && !ddr_selected) begin
					// driven-low rows pull columns, driven-low columns pull rows
					scan = 8'hFF;
					for (row = 0; row < 4; row++)
						for (col = 0; col < 4; col++)
							if (keys_down[4 * row + col]) begin
								if (!port_out[row])
									scan[4 + col] = 1'b0;
								if (!port_out[4 + col])
									scan[row] = 1'b0;
							end
					r.read_data = (scan & ~ddr_mask) | (port_out & ddr_mask);
				end
			end
			OP_WRITE: begin
				if (it.register_select == REG_CONTROL) begin
					ddr_selected = it.write_data[CTRL_DIR_BIT];
					r.direction_chosen = it.write_data[CTRL_DIR_BIT];
				end else if (it.register_select == REG_DATA) begin
					if (ddr_selected)
						ddr_mask = it.write_data;
					else
						port_out = (it.write_data & ddr_mask) | ~ddr_mask;
				end
			end
			OP_KEY_DOWN:     keys_down[it.key_index] = 1'b1;
			OP_KEY_UP:       keys_down[it.key_index] = 1'b0;
			OP_STEP_PRESS:   step_released = 1'b0;
			OP_STEP_RELEASE: step_released = 1'b1;
			OP_CLEAR_KEYS:   keys_down = '0;
			default: ;
		endcase
		r.step_flag = step_released ^ flag_invert;
		return r;
	endfunction

	function automatic item_t make_item(logic [2:0] op, logic [1:0] sel, logic [7:0] data,
			logic [3:0] key);
		item_t it;
		it.operation = op;
		it.register_select = sel;
		it.write_data = data;
		it.key_index = key;
		return it;
	endfunction

	// weighted random item, every field bit randomized underneath
	function automatic item_t random_port_item();
		item_t it;
		int    pick;
		it = item_t'(ITEM_BITS'($urandom));
		pick = $urandom_range(99);
		if (pick < 30) begin
			it.operation = OP_READ;
			if ($urandom_range(9) != 0)
				it.register_select = REG_DATA;
		end else if (pick < 55) begin
			it.operation = OP_WRITE;
			pick = $urandom_range(99);
			if (pick < 80) begin
				it.register_select = REG_DATA;
			end else if (pick < 95) begin
				it.register_select = REG_CONTROL;
				it.write_data[CTRL_DIR_BIT] = ($urandom_range(9) < 3);
			end
		end else if (pick < 70) begin
			it.operation = OP_KEY_DOWN;
		end else if (pick < 80) begin
			it.operation = OP_KEY_UP;
		end else if (pick < 84) begin
			it.operation = OP_STEP_PRESS;
		end else if (pick < 88) begin
			it.operation = OP_STEP_RELEASE;
		end else if (pick < 93) begin
			it.operation = OP_CLEAR_KEYS;
		end else if (pick < 96) begin
			it.operation = OP_UNUSED;
		end
		return it;
	endfunction

	task automatic wait_port_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	task automatic write_flag_invert(input logic value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		flag_invert = value;
	endtask

	// select direction, load a random mask, then select output
	task automatic push_port_setup();
		item_t it;
		it = make_item(OP_WRITE, REG_CONTROL, 8'($urandom), 4'($urandom));
		it.write_data[CTRL_DIR_BIT] = 1'b1;
		pending_items.push_back(it);
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'($urandom), 4'($urandom)));
		it = make_item(OP_WRITE, REG_CONTROL, 8'($urandom), 4'($urandom));
		it.write_data[CTRL_DIR_BIT] = 1'b0;
		pending_items.push_back(it);
	endtask

	task automatic run_random_phase(input int n_items);
		int count;
		@(negedge clk);
		push_port_setup();
		count = 3;
		while (count < n_items) begin
			if ($urandom_range(99) < 8) begin
				push_port_setup();
				count += 3;
			end else begin
				pending_items.push_back(random_port_item());
				count++;
			end
		end
		wait_port_drained();
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
				item_valid <= 1'b1;
				item <= pending_items.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	// monitor: score results, then predict for the item taken at this edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (result.read_data !== want.read_data)
						report_mismatch($sformatf("read_data got %h want %h",
							result.read_data, want.read_data));
					if (result.direction_chosen !== want.direction_chosen)
						report_mismatch($sformatf("direction_chosen got %b want %b",
							result.direction_chosen, want.direction_chosen));
					if (result.step_flag !== want.step_flag)
						report_mismatch($sformatf("step_flag got %b want %b",
							result.step_flag, want.step_flag));
				end
			end
			if (item_valid && !item_stall)
				expected_results.push_back(port_predict(item));
		end
	end

	// stimulus sequence
	initial begin
		// directed: unselected and spare registers, both selects, scans, keys, step, unused op
		pending_items.push_back(make_item(OP_READ, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_READ, REG_CONTROL, 8'hFF, 4'hF));
		pending_items.push_back(make_item(OP_READ, REG_SPARE_A, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_READ, REG_SPARE_B, 8'hFF, 4'hF));
		pending_items.push_back(make_item(OP_WRITE, REG_CONTROL, 8'hFF, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_CONTROL, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'hFF, 4'h0));
		pending_items.push_back(make_item(OP_KEY_DOWN, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_KEY_DOWN, REG_DATA, 8'h00, 4'hF));
		pending_items.push_back(make_item(OP_KEY_DOWN, REG_DATA, 8'h00, 4'h6));
		pending_items.push_back(make_item(OP_READ, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_CONTROL, 8'h04, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'h0F, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_CONTROL, 8'hFB, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'h0E, 4'h0));
		pending_items.push_back(make_item(OP_READ, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_KEY_UP, REG_DATA, 8'hFF, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_SPARE_A, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_WRITE, REG_SPARE_B, 8'hFF, 4'h0));
		pending_items.push_back(make_item(OP_STEP_PRESS, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_STEP_RELEASE, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_CLEAR_KEYS, REG_DATA, 8'h00, 4'h0));
		pending_items.push_back(make_item(OP_UNUSED, REG_SPARE_B, 8'hFF, 4'hF));
		pending_items.push_back(make_item(OP_READ, REG_DATA, 8'h00, 4'h0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_port_drained();

		// random phases across both inversion settings
		write_flag_invert(1'b1);
		run_random_phase(150);
		write_flag_invert(1'b0);
		steady = 1'b1;
		run_random_phase(150);
		steady = 1'b0;
		write_flag_invert(1'b1);
		run_random_phase(150);

		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("pia_port_keypad_matrix: match");
		else
			$display("pia_port_keypad_matrix: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("pia_port_keypad_matrix: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pia_kpm_pkg.sv
hw/rtl/pia_kpm_input.sv
hw/rtl/pia_kpm_core.sv
hw/rtl/pia_kpm_result.sv
hw/rtl/pia_port_keypad_matrix.sv
bench/pia_port_keypad_matrix_test.sv
